@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every edge outside reset.
`define SWR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SWR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/swr_pkg.sv @@
`default_nettype none

package swr_pkg;

  localparam int unsigned DEF_MAX_PACKET = 32;

  localparam logic [7:0]  TARGET_RESET   = 8'd0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [7:0]  EXPECTED_RESET = 8'd1;
  localparam logic [7:0]  SEQ_LIMIT      = 8'd128;

  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_K = 8'h4B;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TARGET  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    SRC_MEM  = 3'd0,
    SRC_CSUM = 3'd1,
    SRC_B0   = 3'd2,
    SRC_B1   = 3'd3,
    SRC_B2   = 3'd4,
    SRC_B3   = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    CND_NEXT     = 2'd0,
    CND_JUMP     = 2'd1,
    CND_LOOP     = 2'd2,
    CND_DISPATCH = 2'd3
  } cond_e;

  localparam int unsigned StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_PLOAD = 3'd1;
  localparam step_t STEP_PEMIT = 3'd2;
  localparam step_t STEP_F0    = 3'd3;
  localparam step_t STEP_F1    = 3'd4;
  localparam step_t STEP_F2    = 3'd5;
  localparam step_t STEP_F3    = 3'd6;
  localparam step_t STEP_F4    = 3'd7;

  typedef struct packed {
    logic  emit;
    logic  kind;
    logic  eor;
    src_e  src;
    cond_e cond;
    step_t target;
  } ctrl_t;

  // Microcode ROM
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '{emit: 1'b0, kind: KIND_FRAME, eor: 1'b0, src: SRC_MEM, cond: CND_NEXT,
          target: STEP_IDLE};
    case (step)
      STEP_IDLE:  c.cond = CND_DISPATCH;
      STEP_PLOAD: c.cond = CND_NEXT;
      STEP_PEMIT: begin
        c.emit = 1'b1;
        c.kind = KIND_PAYLOAD;
        c.src  = SRC_MEM;
        c.cond = CND_LOOP;
      end
      STEP_F0: begin
        c.emit = 1'b1;
        c.src  = SRC_CSUM;
      end
      STEP_F1: begin
        c.emit = 1'b1;
        c.src  = SRC_B0;
      end
      STEP_F2: begin
        c.emit = 1'b1;
        c.src  = SRC_B1;
      end
      STEP_F3: begin
        c.emit = 1'b1;
        c.src  = SRC_B2;
      end
      STEP_F4: begin
        c.emit   = 1'b1;
        c.src    = SRC_B3;
        c.eor    = 1'b1;
        c.cond   = CND_JUMP;
        c.target = STEP_IDLE;
      end
      default: c.cond = CND_JUMP;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] frame_byte(input logic is_ack, input src_e sel,
                                            input logic [7:0] num);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] r;
    b0 = is_ack ? CH_A : CH_G;
    b1 = is_ack ? CH_C : CH_E;
    b2 = is_ack ? CH_K : CH_T;
    case (sel)
      SRC_CSUM: r = b0 ^ b1 ^ b2 ^ num;
      SRC_B0:   r = b0;
      SRC_B1:   r = b1;
      SRC_B2:   r = b2;
      SRC_B3:   r = num;
      default:  r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/swr_store.sv @@
`default_nettype none

module swr_store #(
  parameter int unsigned Depth = swr_pkg::DEF_MAX_PACKET
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/stop_and_wait_receiver_core.sv @@
// Stop-and-wait ARQ receiver.
// Input channel (in_valid_i/in_ready_o) carries one request per command: a
// received packet byte, a timer tick or a start. Output channel
// (out_valid_o/out_ready_i) returns delivered payload bytes (kind 0) and
// transmitted GET/ACK frame bytes (kind 1, checksum first); end_of_run_o marks
// the last result of a request. Configuration sits on the APB port: target
// message at 0x0, timeout in ticks at 0x4.
// A microcoded step sequencer emits one byte per cycle through the output
// register while the receiver does not stall it; a frame is checksum, three
// letters and the number, and a packet end with payload first passes the
// PLOAD step, which covers the registered read of the packet buffer, then
// emits the payload bytes and then the frame. in_ready_o is high only while
// the sequencer sits at its idle step.
// A stalled receiver holds the output register and keeps the sequencer at its
// emitting steps. Reset clears configuration, protocol state, step and output
// valid; the other registers and the packet buffer are not reset.
`default_nettype none

`include "assert_macros.svh"

module stop_and_wait_receiver_core #(
  parameter int unsigned MaxPacket = swr_pkg::DEF_MAX_PACKET
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic      [7:0]  value_o,
  output logic             end_of_run_o,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import swr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPacket + 1);
  localparam int unsigned IdxW = $clog2(MaxPacket);

  logic [7:0]  target_q;
  logic [15:0] timeout_q;

  logic [7:0]  expected_q, expected_d;
  logic        total_known_q, total_known_d;
  logic [7:0]  total_count_q, total_count_d;
  logic        armed_q, armed_d;
  logic [15:0] timer_q, timer_d;
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic [7:0]  xor_q, xor_d;
  logic        too_long_q, too_long_d;
  logic [7:0]  byte0_q, byte0_d;
  logic [7:0]  byte1_q, byte1_d;
  logic [7:0]  byte2_q, byte2_d;

  step_t       step_q, step_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0] pay_last_q, pay_last_d;
  logic        frame_ack_q, frame_ack_d;
  logic [7:0]  frame_num_q, frame_num_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  value_q, value_d;
  logic        eor_q, eor_d;

  logic        in_accept;
  logic        in_range;
  logic [7:0]  xor_new;
  logic        too_long_new;
  logic [7:0]  seq;
  logic [7:0]  tot_eff;
  logic        pkt_ok;
  logic [15:0] arm_cnt;
  logic [7:0]  exp_inc;
  logic        ack_arm_ok;
  logic        go_pay;
  logic        go_frame;
  logic        mem_we;
  logic [7:0]  mem_rdata;
  ctrl_t       ctrl;
  logic        out_free;
  logic        step_adv;
  logic        emit_fire;

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_TARGET:  prdata = {24'd0, target_q};
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_e'(paddr[2]))
        REG_TARGET:  target_q  <= pwdata[7:0];
        REG_TIMEOUT: timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Request handling
  assign in_ready_o = (step_q == STEP_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign in_range     = byte_count_q < CntW'(MaxPacket);
  assign xor_new      = (in_range && byte_count_q != '0) ? (xor_q ^ data_byte_i) : xor_q;
  assign too_long_new = too_long_q | ~in_range;
  assign seq          = {1'b0, byte1_q[6:0]};
  assign tot_eff      = (byte_count_q == CntW'(2)) ? {1'b0, data_byte_i[6:0]}
                                                   : {1'b0, byte2_q[6:0]};
  assign pkt_ok       = last_byte_i && !too_long_new && (byte_count_q >= CntW'(2)) &&
                        (xor_new == byte0_q);
  assign arm_cnt      = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  assign exp_inc      = expected_q + 8'd1;
  assign ack_arm_ok   = !total_known_q || (expected_q <= total_count_q);
  assign mem_we       = in_accept && (command_i == CMD_BYTE) && in_range;

  always_comb begin
    expected_d    = expected_q;
    total_known_d = total_known_q;
    total_count_d = total_count_q;
    armed_d       = armed_q;
    timer_d       = timer_q;
    byte_count_d  = byte_count_q;
    xor_d         = xor_q;
    too_long_d    = too_long_q;
    byte0_d       = byte0_q;
    byte1_d       = byte1_q;
    byte2_d       = byte2_q;
    pay_last_d    = pay_last_q;
    frame_ack_d   = frame_ack_q;
    frame_num_d   = frame_num_q;
    go_pay        = 1'b0;
    go_frame      = 1'b0;
    if (in_accept) begin
      case (command_i)
        CMD_BYTE: begin
          if (byte_count_q == CntW'(0)) byte0_d = data_byte_i;
          if (byte_count_q == CntW'(1)) byte1_d = data_byte_i;
          if (byte_count_q == CntW'(2)) byte2_d = data_byte_i;
          if (last_byte_i) begin
            byte_count_d = '0;
            xor_d        = 8'd0;
            too_long_d   = 1'b0;
            if (pkt_ok && seq == expected_q) begin
              total_known_d = 1'b1;
              total_count_d = tot_eff;
              expected_d    = exp_inc;
              go_frame      = 1'b1;
              frame_ack_d   = 1'b1;
              frame_num_d   = seq;
              go_pay        = byte_count_q >= CntW'(3);
              pay_last_d    = byte_count_q[IdxW-1:0];
              if (exp_inc <= tot_eff) begin
                armed_d = 1'b1;
                timer_d = arm_cnt;
              end else begin
                armed_d = 1'b0;
                timer_d = 16'd0;
              end
            end else if (pkt_ok && seq < expected_q) begin
              go_frame    = 1'b1;
              frame_ack_d = 1'b1;
              frame_num_d = expected_q - 8'd1;
              armed_d     = ack_arm_ok;
              timer_d     = ack_arm_ok ? arm_cnt : 16'd0;
            end
          end else begin
            xor_d      = xor_new;
            too_long_d = too_long_new;
            if (in_range) byte_count_d = byte_count_q + CntW'(1);
          end
        end
        CMD_TICK: begin
          if (armed_q) begin
            if (timer_q <= 16'd1) begin
              go_frame = 1'b1;
              if (expected_q == EXPECTED_RESET) begin
                frame_ack_d = 1'b0;
                frame_num_d = target_q;
                armed_d     = 1'b1;
                timer_d     = arm_cnt;
              end else begin
                frame_ack_d = 1'b1;
                frame_num_d = expected_q - 8'd1;
                armed_d     = ack_arm_ok;
                timer_d     = ack_arm_ok ? arm_cnt : 16'd0;
              end
            end else begin
              timer_d = timer_q - 16'd1;
            end
          end
        end
        CMD_START: begin
          go_frame    = 1'b1;
          frame_ack_d = 1'b0;
          frame_num_d = target_q;
          armed_d     = 1'b1;
          timer_d     = arm_cnt;
        end
        default: ;
      endcase
    end
  end

  // Packet buffer
  swr_store #(
    .Depth (MaxPacket)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (byte_count_q[IdxW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rd_ptr_d),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  assign ctrl      = ucode(step_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign step_adv  = !ctrl.emit || out_free;
  assign emit_fire = ctrl.emit && out_free;

  always_comb begin
    step_d   = step_q;
    rd_ptr_d = rd_ptr_q;
    case (ctrl.cond)
      CND_DISPATCH: begin
        if (go_pay) begin
          step_d   = STEP_PLOAD;
          rd_ptr_d = IdxW'(3);
        end else if (go_frame) begin
          step_d = STEP_F0;
        end
      end
      CND_NEXT: if (step_adv) step_d = step_q + StepW'(1);
      CND_JUMP: if (step_adv) step_d = ctrl.target;
      CND_LOOP: begin
        if (step_adv) begin
          if (rd_ptr_q == pay_last_q) begin
            step_d = step_q + StepW'(1);
          end else begin
            rd_ptr_d = rd_ptr_q + IdxW'(1);
          end
        end
      end
      default: step_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    value_d     = value_q;
    eor_d       = eor_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      kind_d      = ctrl.kind;
      eor_d       = ctrl.eor;
      value_d     = (ctrl.src == SRC_MEM) ? mem_rdata
                                          : frame_byte(frame_ack_q, ctrl.src, frame_num_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign end_of_run_o = eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q    <= EXPECTED_RESET;
      total_known_q <= 1'b0;
      total_count_q <= 8'd0;
      armed_q       <= 1'b0;
      timer_q       <= 16'd0;
      byte_count_q  <= '0;
      xor_q         <= 8'd0;
      too_long_q    <= 1'b0;
      step_q        <= STEP_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      expected_q    <= expected_d;
      total_known_q <= total_known_d;
      total_count_q <= total_count_d;
      armed_q       <= armed_d;
      timer_q       <= timer_d;
      byte_count_q  <= byte_count_d;
      xor_q         <= xor_d;
      too_long_q    <= too_long_d;
      step_q        <= step_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte0_q     <= byte0_d;
    byte1_q     <= byte1_d;
    byte2_q     <= byte2_d;
    rd_ptr_q    <= rd_ptr_d;
    pay_last_q  <= pay_last_d;
    frame_ack_q <= frame_ack_d;
    frame_num_q <= frame_num_d;
    kind_q      <= kind_d;
    value_q     <= value_d;
    eor_q       <= eor_d;
  end

  `SWR_ASSERT(a_seq_limit, expected_q <= SEQ_LIMIT, "expected number beyond limit")
  `SWR_ASSERT_IMP(a_timer_nonzero, armed_q, timer_q != 16'd0, "armed timer at zero")
  `SWR_ASSERT_IMP(a_pay_ptr, step_q == STEP_PEMIT, rd_ptr_q <= pay_last_q, "payload overrun")
  `SWR_ASSERT_NXT(a_dispatch, in_accept && go_frame, step_q != STEP_IDLE, "frame not started")

endmodule

`default_nettype wire
